// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define DKEF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition a implies condition b in the next cycle
`define DKEF_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define DKEF_ASSERT(label, clk, rst, prop)
`define DKEF_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// ===== hw/rtl/dkef_pkg.sv =====
`default_nettype none

package dkef_pkg;

   localparam int FIFO_DEPTH = 128;
   localparam int NUM_KEYS   = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CNT_W      = 10;
   localparam int EVENT_W    = 4;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(20);

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_EDGE = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] key_index;
      logic [7:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic       read_valid;
      logic [2:0] event_key;
      logic       event_level;
      logic       buffer_nonempty;
      logic [6:0] entries_held;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic edge_load;
      logic tick_step;
      logic read_step;
      logic finish;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic key_last;
      logic out_free;
   } sts_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EDGE = 5'b00010,
      S_TICK = 5'b00100,
      S_READ = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dkef_ram.sv =====
`default_nettype none

module dkef_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dkef_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module dkef_ctrl
   import dkef_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_command,
   output logic            req_stall,
   input  wire sts_type    sts,
   output ctl_type         ctl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_item = 1'b1;
               case (req_command)
                  CMD_TICK: state_in = S_TICK;
                  CMD_EDGE: state_in = S_EDGE;
                  CMD_READ: state_in = S_READ;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_EDGE: begin
            ctl.edge_load = 1'b1;
            state_in      = S_DONE;
         end
         S_TICK: begin
            // one key countdown per cycle, ascending key order
            ctl.tick_step = 1'b1;
            if (sts.key_last) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            ctl.read_step = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `DKEF_ASSERT_NEXT(a_tick_runs_all_keys, clock, reset,
      state_ff == S_TICK && !sts.key_last, state_ff == S_TICK)
   `DKEF_ASSERT_NEXT(a_done_waits_for_output, clock, reset,
      state_ff == S_DONE && !sts.out_free, state_ff == S_DONE)

endmodule

`default_nettype wire

// ===== hw/rtl/dkef_dp.sv =====
`default_nettype none
`include "assert_macros.svh"

module dkef_dp
   import dkef_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req_data,
   input  wire logic             csr_valid,
   input  wire logic [CNT_W-1:0] csr_data,
   input  wire ctl_type          ctl,
   output sts_type               sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   req_type          item_ff, item_in;
   logic [CNT_W-1:0] ticks_ff, ticks_in;
   logic [CNT_W-1:0] count_ff [NUM_KEYS];
   logic [CNT_W-1:0] count_in [NUM_KEYS];
   logic [KEY_W-1:0] key_cnt_ff, key_cnt_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             pop_ff, pop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]   cur_count;
   logic [CNT_W-1:0]   dec_count;
   logic [PTR_W-1:0]   entries;
   logic               fifo_empty;
   logic               fifo_full;
   logic               ram_wr_en;
   logic [EVENT_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [EVENT_W-1:0] ram_rd_data;

   dkef_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (FIFO_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_data)
   );

   assign entries    = wp_ff - rp_ff;
   assign fifo_empty = (rp_ff == wp_ff);
   // one slot stays free
   assign fifo_full  = (PTR_W'(wp_ff + 1'b1) == rp_ff);
   assign cur_count  = count_ff[key_cnt_ff];
   assign dec_count  = cur_count - 1'b1;

   assign sts.key_last = (key_cnt_ff == KEY_W'(NUM_KEYS - 1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      item_in      = item_ff;
      ticks_in     = ticks_ff;
      count_in     = count_ff;
      key_cnt_in   = key_cnt_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      pop_in       = pop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = {key_cnt_ff, item_ff.pin_levels[key_cnt_ff]};
      ram_rd_en    = 1'b0;

      if (csr_valid) begin
         ticks_in = csr_data;
      end

      if (ctl.load_item) begin
         item_in    = req_data;
         key_cnt_in = '0;
         pop_in     = 1'b0;
      end

      if (ctl.edge_load) begin
         // a zero setting counts as one tick
         count_in[item_ff.key_index] = (ticks_ff == '0) ? CNT_W'(1) : ticks_ff;
      end

      if (ctl.tick_step) begin
         key_cnt_in = key_cnt_ff + 1'b1;
         if (cur_count != '0) begin
            count_in[key_cnt_ff] = dec_count;
            // countdown expired: push event unless full
            if (dec_count == '0 && !fifo_full) begin
               ram_wr_en = 1'b1;
               wp_in     = wp_ff + 1'b1;
            end
         end
      end

      if (ctl.read_step && !fifo_empty) begin
         ram_rd_en = 1'b1;
         rp_in     = rp_ff + 1'b1;
         pop_in    = 1'b1;
      end

      if (ctl.finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_valid      = pop_ff;
         rsp_data_in.event_key       = pop_ff ? ram_rd_data[EVENT_W-1:1] : 3'd0;
         rsp_data_in.event_level     = pop_ff ? ram_rd_data[0] : 1'b0;
         rsp_data_in.buffer_nonempty = !fifo_empty;
         rsp_data_in.entries_held    = entries;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= DEBOUNCE_RESET;
         count_ff     <= '{default: '0};
         key_cnt_ff   <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ticks_ff     <= ticks_in;
         count_ff     <= count_in;
         key_cnt_ff   <= key_cnt_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DKEF_ASSERT(a_no_push_when_full, clock, reset, ram_wr_en |-> !fifo_full)
   `DKEF_ASSERT(a_no_pop_when_empty, clock, reset, ram_rd_en |-> !fifo_empty)
   `DKEF_ASSERT(a_finish_into_free_slot, clock, reset, ctl.finish |-> sts.out_free)

endmodule

`default_nettype wire

// ===== hw/rtl/debounced_key_event_fifo.sv =====
`default_nettype none

// Per-key debounce with an event queue. Each accepted request gives exactly one
// response: an edge request restarts its key's countdown, a tick request walks
// the key countdowns one key per cycle and queues an event (key, sampled pin
// level) for every countdown that expires, and a read request pops the oldest
// event. The queue holds up to FIFO_DEPTH-1 events; events arriving when full
// are lost. A tick visits the keys one after another, since the single
// countdown update and queue write port are shared across keys; a read
// request goes through the registered queue memory.
// A new request can be accepted while the previous response is still stalled.
// The debounce register must be written through the csr port only while no
// request is in flight; the block does not enforce this. csr_ready is always high.
module debounced_key_event_fifo
   import dkef_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_data
);

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   dkef_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .sts         (sts),
      .ctl         (ctl)
   );

   dkef_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
